>>> rtl/meu_pkg.sv
// package for the modular exponentiation unit: widths, register indexes, cell types
package meu_pkg;
  localparam int OperandBits = 31;
  localparam int FieldBits = 31;
  localparam int CfgIndexBits = 1;
  localparam logic [CfgIndexBits-1:0] RegExponent = 1'b0;
  localparam logic [CfgIndexBits-1:0] RegModulus = 1'b1;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;
endpackage

>>> rtl/meu_mod_mult.sv
// bit-serial shift-add-reduce modular multiplier built from a chain of cells
module meu_mod_mult
  import meu_pkg::*;
#(
  parameter int OPERAND_BITS = OperandBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [OPERAND_BITS-1:0] a,
  input  logic [OPERAND_BITS-1:0] b,
  input  logic [OPERAND_BITS-1:0] m,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] p
);
  localparam int W = OPERAND_BITS;
  localparam int CW = $clog2(W + 1);

  cell_ctrl_t ctrl;
  logic [W-1:0] bits;
  logic [W-1:0] bits_next;
  logic [W:0] acc;
  logic [W+1:0] dbl;
  logic [W+1:0] sum;
  logic [W+1:0] r1;
  logic [W+1:0] r2;
  logic [W-1:0] addend;
  logic [W-1:0] ared;
  logic [W-1:0] areg;
  logic [CW-1:0] count;
  logic running;

  assign ctrl.load = go;
  assign ctrl.shift = running;

  // each cell holds one multiplier bit and passes it toward the msb end
  for (genvar i = 0; i < W; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign bits_next[i] = ctrl.load ? b[i] : 1'b0;
    end else begin : g_rest
      assign bits_next[i] = ctrl.load ? b[i] : bits[i-1];
    end
    always_ff @(posedge clk) begin
      if (ctrl.load || ctrl.shift) begin
        bits[i] <= bits_next[i];
      end
    end
  end

  // a reduced once so addend stays below m
  assign ared = (a >= m) ? (a - m) : a;
  assign dbl = {acc, 1'b0};
  assign r1 = (dbl >= {2'b00, m}) ? (dbl - {2'b00, m}) : dbl;
  assign addend = bits[W-1] ? areg : '0;
  assign sum = r1 + {2'b00, addend};
  assign r2 = (sum >= {2'b00, m}) ? (sum - {2'b00, m}) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == CW'(W - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      areg <= ared;
    end else if (running) begin
      acc <= r2[W:0];
    end
  end

  assign p = acc[W-1:0];

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running)) else $error("done without run");
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (running && !go && m != '0) |=> ({1'b0, m} > acc || $past(go)))
    else $error("accumulator not reduced");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("done while running");
`endif
endmodule

>>> rtl/modular_exponentiation_unit.sv
// modular exponentiation unit: right-to-left square-and-multiply
// throughput: one item at a time; busy is high from start until the result strobe
// the shared bit-serial multiplier runs one bit per cycle, twice per exponent bit
// rst is synchronous: exponent 0, modulus 1, block idle; receiver cannot stall
module modular_exponentiation_unit
  import meu_pkg::*;
#(
  parameter int OPERAND_BITS = OperandBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [FieldBits-1:0]    base_value,
  input  logic                    last_in,
  output logic                    strobe,
  output logic [FieldBits-1:0]    residue,
  output logic                    last_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [FieldBits-1:0]    cfg_data
);
  localparam int W = OPERAND_BITS;
  localparam int BW = $clog2(W + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul = 2'd1;
  localparam logic [1:0] StSq = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  logic [W-1:0] accv;
  logic [W-1:0] sq;
  logic [BW-1:0] bitn;
  logic last_q;
  logic go;
  logic mdone;
  logic [W-1:0] ma;
  logic [W-1:0] mb;
  logic [W-1:0] mp;
  logic [W-1:0] in_base;
  logic [W-1:0] one_mod;

  assign cfg_ready = 1'b1;
  assign busy = (state != StIdle);
  assign in_base = W'(base_value);
  assign one_mod = (modulus == W'(1)) ? '0 : W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus <= W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegExponent: exponent <= W'(cfg_data);
        RegModulus: modulus <= W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign ma = (state == StMul) ? accv : sq;
  assign mb = sq;

  meu_mod_mult #(.OPERAND_BITS(W)) u_mult (
    .clk(clk), .rst(rst), .go(go), .a(ma), .b(mb), .m(modulus), .done(mdone), .p(mp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      go <= 1'b0;
      strobe <= 1'b0;
      bitn <= '0;
    end else begin
      go <= 1'b0;
      strobe <= 1'b0;
      unique case (state)
        StIdle: begin
          if (start) begin
            accv <= one_mod;
            sq <= in_base;
            last_q <= last_in;
            bitn <= '0;
            if (modulus == '0) begin
              state <= StDone;
            end else begin
              state <= StMul;
              go <= 1'b1;
            end
          end
        end
        StMul: begin
          if (mdone) begin
            if (exponent[bitn[$clog2(W)-1:0]]) begin
              accv <= mp;
            end
            // first product is 1 times base, the base reduced below the modulus
            if (bitn == '0) begin
              sq <= mp;
            end
            state <= StSq;
            go <= 1'b1;
          end
        end
        StSq: begin
          if (mdone) begin
            sq <= mp;
            if (bitn == BW'(W - 1)) begin
              state <= StDone;
            end else begin
              bitn <= bitn + 1'b1;
              state <= StMul;
              go <= 1'b1;
            end
          end
        end
        StDone: begin
          strobe <= 1'b1;
          residue <= (modulus == '0) ? '0 : FieldBits'(accv);
          last_out <= last_q;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_done: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == StDone) else $error("strobe outside done");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_bit_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bitn < BW'(W)) else $error("bit index out of range");
`endif
endmodule
